// ===== sv/esc_rts_pkg.sv =====
// Shared types and constants for the reverse throttle sequencer.
`timescale 1ns / 1ps

package esc_rts_pkg;

   localparam int WidthBits   = 12;
   localparam int TimeBits    = 16;
   localparam int ChannelBits = 4;
   localparam int PhaseBits   = 2;
   localparam int ThrottleBits = 16;
   localparam int NowBits     = 32;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 16;

   // reverse arming phases
   localparam logic [PhaseBits-1:0] PH_READY   = 2'd0;
   localparam logic [PhaseBits-1:0] PH_BRAKE   = 2'd1;
   localparam logic [PhaseBits-1:0] PH_PAUSE   = 2'd2;
   localparam logic [PhaseBits-1:0] PH_ENGAGED = 2'd3;

   // register indexes
   localparam logic [CsrIndexBits-1:0] REG_NEUTRAL_WIDTH       = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_FORWARD_CREEP_WIDTH = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_FORWARD_MAX_WIDTH   = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_REVERSE_CREEP_WIDTH = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_REVERSE_MAX_WIDTH   = 3'd4;
   localparam logic [CsrIndexBits-1:0] REG_BRAKE_TIME_MS       = 3'd5;
   localparam logic [CsrIndexBits-1:0] REG_PAUSE_TIME_MS       = 3'd6;
   localparam logic [CsrIndexBits-1:0] REG_OUTPUT_CHANNEL      = 3'd7;

   // register reset values
   localparam logic [WidthBits-1:0]   RST_NEUTRAL_WIDTH       = 12'd1500;
   localparam logic [WidthBits-1:0]   RST_FORWARD_CREEP_WIDTH = 12'd1550;
   localparam logic [WidthBits-1:0]   RST_FORWARD_MAX_WIDTH   = 12'd2000;
   localparam logic [WidthBits-1:0]   RST_REVERSE_CREEP_WIDTH = 12'd1450;
   localparam logic [WidthBits-1:0]   RST_REVERSE_MAX_WIDTH   = 12'd1000;
   localparam logic [TimeBits-1:0]    RST_BRAKE_TIME_MS       = 16'd100;
   localparam logic [TimeBits-1:0]    RST_PAUSE_TIME_MS       = 16'd100;
   localparam logic [ChannelBits-1:0] RST_OUTPUT_CHANNEL      = 4'd0;

   typedef struct packed {
      logic [WidthBits-1:0]   neutral_width;
      logic [WidthBits-1:0]   forward_creep_width;
      logic [WidthBits-1:0]   forward_max_width;
      logic [WidthBits-1:0]   reverse_creep_width;
      logic [WidthBits-1:0]   reverse_max_width;
      logic [TimeBits-1:0]    brake_time_ms;
      logic [TimeBits-1:0]    pause_time_ms;
      logic [ChannelBits-1:0] output_channel;
   } cfg_type;

   typedef struct packed {
      logic [WidthBits-1:0] pulse_width;
      logic [PhaseBits-1:0] phase;
      logic [NowBits-1:0]   entry_time;
   } step_type;

endpackage

// ===== sv/esc_rts_csr.sv =====
// Configuration register file of the reverse throttle sequencer.
`timescale 1ns / 1ps

module esc_rts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [esc_rts_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [esc_rts_pkg::CsrDataBits-1:0]  csr_wdata,
   output esc_rts_pkg::cfg_type                cfg
);

   esc_rts_pkg::cfg_type cfg_ff;
   esc_rts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            esc_rts_pkg::REG_NEUTRAL_WIDTH:       cfg_in.neutral_width = csr_wdata[11:0];
            esc_rts_pkg::REG_FORWARD_CREEP_WIDTH: cfg_in.forward_creep_width = csr_wdata[11:0];
            esc_rts_pkg::REG_FORWARD_MAX_WIDTH:   cfg_in.forward_max_width = csr_wdata[11:0];
            esc_rts_pkg::REG_REVERSE_CREEP_WIDTH: cfg_in.reverse_creep_width = csr_wdata[11:0];
            esc_rts_pkg::REG_REVERSE_MAX_WIDTH:   cfg_in.reverse_max_width = csr_wdata[11:0];
            esc_rts_pkg::REG_BRAKE_TIME_MS:       cfg_in.brake_time_ms = csr_wdata;
            esc_rts_pkg::REG_PAUSE_TIME_MS:       cfg_in.pause_time_ms = csr_wdata;
            esc_rts_pkg::REG_OUTPUT_CHANNEL:      cfg_in.output_channel = csr_wdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_width       <= esc_rts_pkg::RST_NEUTRAL_WIDTH;
         cfg_ff.forward_creep_width <= esc_rts_pkg::RST_FORWARD_CREEP_WIDTH;
         cfg_ff.forward_max_width   <= esc_rts_pkg::RST_FORWARD_MAX_WIDTH;
         cfg_ff.reverse_creep_width <= esc_rts_pkg::RST_REVERSE_CREEP_WIDTH;
         cfg_ff.reverse_max_width   <= esc_rts_pkg::RST_REVERSE_MAX_WIDTH;
         cfg_ff.brake_time_ms       <= esc_rts_pkg::RST_BRAKE_TIME_MS;
         cfg_ff.pause_time_ms       <= esc_rts_pkg::RST_PAUSE_TIME_MS;
         cfg_ff.output_channel      <= esc_rts_pkg::RST_OUTPUT_CHANNEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/esc_rts_step.sv =====
// Next phase, entry time and pulse width for one command.
`timescale 1ns / 1ps

module esc_rts_step (
   input  esc_rts_pkg::cfg_type                  cfg,
   input  logic [esc_rts_pkg::PhaseBits-1:0]     phase,
   input  logic [esc_rts_pkg::NowBits-1:0]       entry_time,
   input  logic                                  cmd,
   input  logic signed [esc_rts_pkg::ThrottleBits-1:0] throttle_value,
   input  logic [esc_rts_pkg::NowBits-1:0]       now_ms,
   output esc_rts_pkg::step_type                 step
);

   logic [esc_rts_pkg::NowBits-1:0]      elapsed;
   logic                                 from_ready;
   logic                                 brake_done;
   logic                                 pause_done;
   logic                                 pause_zero;
   logic                                 is_neg;
   logic                                 is_zero;
   logic [esc_rts_pkg::ThrottleBits-1:0] mag;
   logic [esc_rts_pkg::WidthBits-1:0]    lo;
   logic [esc_rts_pkg::WidthBits-1:0]    hi;
   logic signed [12:0]                   diff;
   logic signed [16:0]                   mag_s;
   logic signed [29:0]                   prod;
   logic signed [29:0]                   num;
   logic [esc_rts_pkg::WidthBits-1:0]    blend;

   // elapsed time wraps modulo 2^32
   assign elapsed    = now_ms - entry_time;
   assign from_ready = (phase == esc_rts_pkg::PH_READY);
   assign brake_done = from_ready ? (cfg.brake_time_ms == '0)
                     : ((elapsed[31:16] != '0) || (elapsed[15:0] >= cfg.brake_time_ms));
   assign pause_done = (elapsed[31:16] != '0) || (elapsed[15:0] >= cfg.pause_time_ms);
   assign pause_zero = (cfg.pause_time_ms == '0);

   assign is_neg  = throttle_value[15];
   assign is_zero = (throttle_value == '0);
   // magnitude 1..32768; the most negative code maps to 0x8000
   assign mag = is_neg ? 16'(-throttle_value) : 16'(throttle_value);

   // lo + (hi - lo) * mag / 32768, floored; the result stays between lo and hi
   assign lo    = is_neg ? cfg.reverse_creep_width : cfg.forward_creep_width;
   assign hi    = is_neg ? cfg.reverse_max_width : cfg.forward_max_width;
   assign diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
   assign mag_s = $signed({1'b0, mag});
   assign prod  = diff * mag_s;
   assign num   = prod + $signed({3'b000, lo, 15'd0});
   assign blend = num[26:15];

   always_comb begin
      step.pulse_width = cfg.neutral_width;
      step.phase       = phase;
      step.entry_time  = entry_time;
      if (cmd) begin
         step.phase = esc_rts_pkg::PH_READY;
      end else if (is_zero) begin
         if (phase == esc_rts_pkg::PH_PAUSE) begin
            if (pause_done) begin
               step.phase = esc_rts_pkg::PH_ENGAGED;
            end
         end else if (phase != esc_rts_pkg::PH_ENGAGED) begin
            step.phase = esc_rts_pkg::PH_READY;
         end
      end else if (!is_neg) begin
         step.phase       = esc_rts_pkg::PH_READY;
         step.pulse_width = blend;
      end else begin
         case (phase)
            esc_rts_pkg::PH_READY, esc_rts_pkg::PH_BRAKE: begin
               if (!brake_done) begin
                  step.phase       = esc_rts_pkg::PH_BRAKE;
                  step.pulse_width = cfg.reverse_creep_width;
                  if (from_ready) begin
                     step.entry_time = now_ms;
                  end
               end else if (!pause_zero) begin
                  step.phase      = esc_rts_pkg::PH_PAUSE;
                  step.entry_time = now_ms;
               end else begin
                  step.phase       = esc_rts_pkg::PH_ENGAGED;
                  step.entry_time  = now_ms;
                  step.pulse_width = blend;
               end
            end
            esc_rts_pkg::PH_PAUSE: begin
               if (pause_done) begin
                  step.phase       = esc_rts_pkg::PH_ENGAGED;
                  step.pulse_width = blend;
               end
            end
            default: begin
               step.pulse_width = blend;
            end
         endcase
      end
   end

endmodule

// ===== sv/esc_reverse_throttle_sequencer.sv =====
// Top level of the reverse-arming throttle sequencer.
`timescale 1ns / 1ps

// Turns throttle commands and stops into servo pulse widths for a speed controller.
// Request channel (req_*): one command per transfer, cmd selects throttle or stop,
// throttle_value is signed Q1.15 and now_ms a free-running millisecond timestamp.
// Response channel (rsp_*): exactly one result per request, carrying the pulse
// width in microseconds, the configured PWM channel and the arming phase after it.
// Configuration (csr_*): one register written per cycle with csr_wr_en high;
// write only while no request is in flight.
// A transferred request passes through the input register, then the response register.
// Throughput: one request per cycle while the response is not stalled, set by the
// single compute stage between the input register and the response register; the
// phase and entry time feed back into that stage so the next command sees them.
// A stalled response holds in its register; the input register still takes a new
// request while it is empty or while the response register is empty or draining,
// and req_stall rises only when both registers are full and rsp_stall is high.
// Reset clears both valid flags, returns the phase to ready with entry time zero
// and loads the register defaults.

module esc_reverse_throttle_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [esc_rts_pkg::ThrottleBits-1:0] req_throttle_value,
   input  logic [esc_rts_pkg::NowBits-1:0]     req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [esc_rts_pkg::WidthBits-1:0]   rsp_pulse_width,
   output logic [esc_rts_pkg::ChannelBits-1:0] rsp_channel,
   output logic [esc_rts_pkg::PhaseBits-1:0]   rsp_reverse_phase,
   input  logic                                csr_wr_en,
   input  logic [esc_rts_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [esc_rts_pkg::CsrDataBits-1:0]  csr_wdata
);

   esc_rts_pkg::cfg_type  cfg;
   esc_rts_pkg::step_type step;

   // input register
   logic                                       s1_valid_ff;
   logic                                       s1_valid_in;
   logic                                       s1_cmd_ff;
   logic signed [esc_rts_pkg::ThrottleBits-1:0] s1_throttle_ff;
   logic [esc_rts_pkg::NowBits-1:0]            s1_now_ff;

   // arming state
   logic [esc_rts_pkg::PhaseBits-1:0]          phase_ff;
   logic [esc_rts_pkg::NowBits-1:0]            entry_ff;

   // response register
   logic                                       rsp_valid_ff;
   logic                                       rsp_valid_in;
   logic [esc_rts_pkg::WidthBits-1:0]          rsp_width_ff;
   logic [esc_rts_pkg::ChannelBits-1:0]        rsp_channel_ff;
   logic [esc_rts_pkg::PhaseBits-1:0]          rsp_phase_ff;

   logic                                       advance;
   logic                                       req_xfer;

   esc_rts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esc_rts_step u_step (
      .cfg            (cfg),
      .phase          (phase_ff),
      .entry_time     (entry_ff),
      .cmd            (s1_cmd_ff),
      .throttle_value (s1_throttle_ff),
      .now_ms         (s1_now_ff),
      .step           (step)
   );

   // move the input register forward when the response register is free or draining
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      // an empty input register takes a transfer even while the response holds
      if (advance || !s1_valid_ff) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= esc_rts_pkg::PH_READY;
         entry_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit the arming state together with the result it produced
         if (s1_valid_ff && advance) begin
            phase_ff <= step.phase;
            entry_ff <= step.entry_time;
         end
      end
   end

   // payload: capture on transfer, hold while stalled
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff      <= req_cmd;
         s1_throttle_ff <= req_throttle_value;
         s1_now_ff      <= req_now_ms;
      end
      if (s1_valid_ff && advance) begin
         rsp_width_ff   <= step.pulse_width;
         rsp_channel_ff <= cfg.output_channel;
         rsp_phase_ff   <= step.phase;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_width   = rsp_width_ff;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_reverse_phase = rsp_phase_ff;

   // a stop always leaves the sequencer ready
   a_stop_ready: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && s1_cmd_ff) |=> (rsp_phase_ff == esc_rts_pkg::PH_READY))
      else $error("stop did not return phase to ready");

   // the shown phase matches the committed arming state
   a_phase_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_phase_ff == phase_ff))
      else $error("response phase differs from arming state");

   // stall only with a held item in the input register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with free registers");

   // a brake entered from ready records the command time
   a_brake_entry: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && (phase_ff == esc_rts_pkg::PH_READY)
       && (step.phase == esc_rts_pkg::PH_BRAKE))
      |=> (entry_ff == $past(s1_now_ff)))
      else $error("brake entry time not recorded");

endmodule
